[rtl/core/ssgp_pkg.sv]
package ssgp_pkg;

	// Fixed point: positions Q12.8, distances Q13.8, orientation Q2.14, outputs Q1.15
	localparam int COORD_WIDTH = 20;
	localparam int DIFF_W      = COORD_WIDTH + 1;
	localparam int D2_W        = 2 * DIFF_W;
	localparam int POS_W       = 3 * COORD_WIDTH;
	localparam int VEC_W       = 16;
	localparam int ORIENT_W    = 3 * VEC_W;
	localparam int CFG_W       = (POS_W > ORIENT_W) ? POS_W : ORIENT_W;
	localparam int DIST_W      = 21;
	localparam int PROD16_W    = 2 * VEC_W;
	localparam int CROSS_W     = PROD16_W + 1;
	localparam int RMAG_W      = PROD16_W;
	localparam int RAD_W       = 64;
	localparam int ROOT_W      = RAD_W / 2;
	localparam int PROD_W      = 16 + ROOT_W;
	localparam int DEN_W       = PROD_W + 1;
	localparam int QB          = 18;
	localparam int DIV_W       = 64;
	localparam int NLANE       = 7;
	localparam int DP_W        = 2 * QB;
	localparam int DOT_W       = DP_W + 2;

	localparam logic [15:0] UNITY   = 16'h8000;
	localparam logic [15:0] PAN_MAX = 16'h7fff;

	localparam logic [1:0] CFG_POS = 2'd0;
	localparam logic [1:0] CFG_FWD = 2'd1;
	localparam logic [1:0] CFG_UP  = 2'd2;

	typedef struct packed {
		logic [15:0]                    sound_id;
		logic signed [COORD_WIDTH-1:0]  source_x;
		logic signed [COORD_WIDTH-1:0]  source_y;
		logic signed [COORD_WIDTH-1:0]  source_z;
		logic [15:0]                    volume;
		logic [DIST_W-1:0]              min_distance;
		logic [DIST_W-1:0]              max_distance;
		logic [15:0]                    rolloff;
	} req_t;

	typedef struct packed {
		logic [15:0]        sound_id_out;
		logic [15:0]        final_volume;
		logic signed [15:0] pan;
	} res_t;

	// Travels alongside the two square-root lanes
	typedef struct packed {
		logic [15:0]                   sound_id;
		logic [15:0]                   volume;
		logic [DIST_W-1:0]             min_d;
		logic [15:0]                   rolloff;
		logic                          in_min;
		logic                          outside;
		logic [2:0]                    rneg;
		logic [2:0]                    dneg;
		logic [2:0][RMAG_W-1:0]        rmag;
		logic [2:0][DIFF_W-1:0]        dmag;
	} car_t;

	// Travels alongside the divider lanes
	typedef struct packed {
		logic [15:0] sound_id;
		logic [15:0] volume;
		logic        in_min;
		logic        outside;
		logic        den_zero;
		logic        pan_zero;
		logic [2:0]  rneg;
		logic [2:0]  dneg;
	} fin_t;

endpackage

[rtl/core/spatial_sound_gain_and_pan_core.sv]
// Spatial gain and pan for one sound request per transaction. Listener position, forward and up
// vectors are written through the cfg port; the user must write them only while the core is idle,
// which the core does not enforce. Each request yields one result with the inverse-distance
// clamped volume (Q1.15) and a stereo pan (Q1.15, negative is left). Fully pipelined through the
// 32-step bit-per-stage square root and 18-step bit-per-stage restoring dividers: one request per
// cycle, stalling only while both entries of the two-entry output buffer are full.
module spatial_sound_gain_and_pan_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [1:0]                    cfg_index,
	input  logic [ssgp_pkg::CFG_W-1:0]    cfg_data,
	input  logic                          req_valid,
	output logic                          req_ready,
	input  ssgp_pkg::req_t                req,
	output logic                          res_valid,
	input  logic                          res_ready,
	output ssgp_pkg::res_t                res
);
	import ssgp_pkg::*;

	// ---------------- configuration ----------------
	logic [POS_W-1:0]    pos_q;
	logic [ORIENT_W-1:0] fwd_q;
	logic [ORIENT_W-1:0] up_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			fwd_q <= '0;
			up_q  <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_POS: pos_q <= cfg_data[POS_W-1:0];
				CFG_FWD: fwd_q <= cfg_data[ORIENT_W-1:0];
				CFG_UP:  up_q  <= cfg_data[ORIENT_W-1:0];
				default: ;
			endcase
		end
	end

	// ---------------- pipeline control ----------------
	logic en;
	res_t head_q, tail_q, res_c;
	logic head_v_q, tail_v_q;
	logic v_s8;

	assign en        = !tail_v_q;
	assign req_ready = en;

	// ---------------- stage 1: differences and right vector ----------------
	logic signed [COORD_WIDTH-1:0] src [3];
	logic signed [COORD_WIDTH-1:0] lis [3];
	logic signed [VEC_W-1:0]       fv [3];
	logic signed [VEC_W-1:0]       uv [3];
	logic signed [DIFF_W-1:0]      diff_c [3];
	logic signed [PROD16_W-1:0]    pa [3];
	logic signed [PROD16_W-1:0]    pb [3];
	logic signed [CROSS_W-1:0]     cross_c [3];

	always_comb begin
		src[0] = req.source_x;
		src[1] = req.source_y;
		src[2] = req.source_z;
		for (int i = 0; i < 3; i++) begin
			lis[i]    = pos_q[i*COORD_WIDTH +: COORD_WIDTH];
			fv[i]     = fwd_q[i*VEC_W +: VEC_W];
			uv[i]     = up_q[i*VEC_W +: VEC_W];
			diff_c[i] = {src[i][COORD_WIDTH-1], src[i]} - {lis[i][COORD_WIDTH-1], lis[i]};
		end
		pa[0] = fv[1] * uv[2];
		pb[0] = fv[2] * uv[1];
		pa[1] = fv[2] * uv[0];
		pb[1] = fv[0] * uv[2];
		pa[2] = fv[0] * uv[1];
		pb[2] = fv[1] * uv[0];
		for (int i = 0; i < 3; i++)
			cross_c[i] = {pa[i][PROD16_W-1], pa[i]} - {pb[i][PROD16_W-1], pb[i]};
	end

	logic                      v_s1;
	req_t                      req_s1;
	logic signed [DIFF_W-1:0]  diff_s1 [3];
	logic signed [CROSS_W-1:0] cross_s1 [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s1 <= 1'b0;
		else if (en)
			v_s1 <= req_valid;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			req_s1   <= req;
			diff_s1  <= diff_c;
			cross_s1 <= cross_c;
		end
	end

	// ---------------- stage 2: squares and magnitudes ----------------
	logic signed [D2_W-1:0]      dsq_c [3];
	logic signed [2*CROSS_W-1:0] rsq_c [3];
	logic [DIFF_W-1:0]           dneg_v [3];
	logic [CROSS_W-1:0]          rneg_v [3];
	car_t                        car_c2;

	always_comb begin
		car_c2          = '0;
		car_c2.sound_id = req_s1.sound_id;
		car_c2.volume   = req_s1.volume;
		car_c2.min_d    = req_s1.min_distance;
		car_c2.rolloff  = req_s1.rolloff;
		for (int i = 0; i < 3; i++) begin
			dsq_c[i]       = diff_s1[i] * diff_s1[i];
			rsq_c[i]       = cross_s1[i] * cross_s1[i];
			dneg_v[i]      = -diff_s1[i];
			rneg_v[i]      = -cross_s1[i];
			car_c2.dneg[i] = diff_s1[i][DIFF_W-1];
			car_c2.rneg[i] = cross_s1[i][CROSS_W-1];
			car_c2.dmag[i] = diff_s1[i][DIFF_W-1] ? dneg_v[i] : diff_s1[i];
			car_c2.rmag[i] = cross_s1[i][CROSS_W-1] ? rneg_v[i][RMAG_W-1:0]
			                                        : cross_s1[i][RMAG_W-1:0];
		end
	end

	logic                  v_s2;
	car_t                  car_s2;
	logic [D2_W-1:0]       dsq_s2 [3];
	logic [RAD_W-1:0]      rsq_s2 [3];
	logic [2*DIST_W-1:0]   min2_s2, max2_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s2 <= 1'b0;
		else if (en)
			v_s2 <= v_s1;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			car_s2  <= car_c2;
			min2_s2 <= req_s1.min_distance * req_s1.min_distance;
			max2_s2 <= req_s1.max_distance * req_s1.max_distance;
			for (int i = 0; i < 3; i++) begin
				dsq_s2[i] <= dsq_c[i];
				rsq_s2[i] <= rsq_c[i][RAD_W-1:0];
			end
		end
	end

	// ---------------- stage 3: sums, range tests, square root entry ----------------
	logic [D2_W-1:0]  d2_c;
	logic [RAD_W-1:0] rr_c;
	car_t             car_c3;

	always_comb begin
		d2_c          = dsq_s2[0] + dsq_s2[1] + dsq_s2[2];
		rr_c          = rsq_s2[0] + rsq_s2[1] + rsq_s2[2];
		car_c3        = car_s2;
		// minimum test wins when max is not above min
		car_c3.in_min  = RAD_W'(d2_c) <= RAD_W'(min2_s2);
		car_c3.outside = RAD_W'(d2_c) >= RAD_W'(max2_s2);
	end

	logic               v_sq        [ROOT_W+1];
	car_t               car_sq      [ROOT_W+1];
	logic [RAD_W-1:0]   sqd_x_sq    [ROOT_W+1];
	logic [ROOT_W+1:0]  sqd_rem_sq  [ROOT_W+1];
	logic [ROOT_W-1:0]  sqd_root_sq [ROOT_W+1];
	logic [RAD_W-1:0]   sqr_x_sq    [ROOT_W+1];
	logic [ROOT_W+1:0]  sqr_rem_sq  [ROOT_W+1];
	logic [ROOT_W-1:0]  sqr_root_sq [ROOT_W+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_sq[0] <= 1'b0;
		else if (en)
			v_sq[0] <= v_s2;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			car_sq[0]      <= car_c3;
			sqd_x_sq[0]    <= RAD_W'({d2_c, 16'h0000});
			sqd_rem_sq[0]  <= '0;
			sqd_root_sq[0] <= '0;
			sqr_x_sq[0]    <= rr_c;
			sqr_rem_sq[0]  <= '0;
			sqr_root_sq[0] <= '0;
		end
	end

	// ---------------- square roots: one result bit per stage ----------------
	for (genvar k = 0; k < ROOT_W; k++) begin : g_sqrt
		logic [ROOT_W+1:0] dsh, dtr, rsh, rtr;

		always_comb begin
			dsh = {sqd_rem_sq[k][ROOT_W-1:0], sqd_x_sq[k][RAD_W-1 -: 2]};
			dtr = {sqd_root_sq[k], 2'b01};
			rsh = {sqr_rem_sq[k][ROOT_W-1:0], sqr_x_sq[k][RAD_W-1 -: 2]};
			rtr = {sqr_root_sq[k], 2'b01};
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				v_sq[k+1] <= 1'b0;
			else if (en)
				v_sq[k+1] <= v_sq[k];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				car_sq[k+1]   <= car_sq[k];
				sqd_x_sq[k+1] <= sqd_x_sq[k] << 2;
				sqr_x_sq[k+1] <= sqr_x_sq[k] << 2;
				if (dsh >= dtr) begin
					sqd_rem_sq[k+1]  <= dsh - dtr;
					sqd_root_sq[k+1] <= {sqd_root_sq[k][ROOT_W-2:0], 1'b1};
				end else begin
					sqd_rem_sq[k+1]  <= dsh;
					sqd_root_sq[k+1] <= {sqd_root_sq[k][ROOT_W-2:0], 1'b0};
				end
				if (rsh >= rtr) begin
					sqr_rem_sq[k+1]  <= rsh - rtr;
					sqr_root_sq[k+1] <= {sqr_root_sq[k][ROOT_W-2:0], 1'b1};
				end else begin
					sqr_rem_sq[k+1]  <= rsh;
					sqr_root_sq[k+1] <= {sqr_root_sq[k][ROOT_W-2:0], 1'b0};
				end
			end
		end
	end

	// ---------------- stage 4: distance beyond minimum ----------------
	logic [ROOT_W-1:0] dlen_c, mn8_c;

	assign dlen_c = sqd_root_sq[ROOT_W];
	assign mn8_c  = ROOT_W'({car_sq[ROOT_W].min_d, 8'h00});

	logic              v_s4;
	car_t              car_s4;
	logic [ROOT_W-1:0] dlen_s4, rlen_s4, excess_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s4 <= 1'b0;
		else if (en)
			v_s4 <= v_sq[ROOT_W];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			car_s4    <= car_sq[ROOT_W];
			dlen_s4   <= dlen_c;
			rlen_s4   <= sqr_root_sq[ROOT_W];
			excess_s4 <= (dlen_c > mn8_c) ? dlen_c - mn8_c : '0;
		end
	end

	// ---------------- stage 5: rolloff product ----------------
	logic              v_s5;
	car_t              car_s5;
	logic [ROOT_W-1:0] dlen_s5, rlen_s5;
	logic [PROD_W-1:0] prod_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s5 <= 1'b0;
		else if (en)
			v_s5 <= v_s4;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			car_s5  <= car_s4;
			dlen_s5 <= dlen_s4;
			rlen_s5 <= rlen_s4;
			prod_s5 <= PROD_W'(car_s4.rolloff) * PROD_W'(excess_s4);
		end
	end

	// ---------------- stage 6: denominator, divider entry ----------------
	// lane 0 gain, lanes 1..3 right vector components, lanes 4..6 direction components
	logic [DEN_W-1:0] denom_c;
	fin_t             fin_c;

	always_comb begin
		denom_c        = DEN_W'({car_s5.min_d, 20'h00000}) + DEN_W'(prod_s5);
		fin_c.sound_id = car_s5.sound_id;
		fin_c.volume   = car_s5.volume;
		fin_c.in_min   = car_s5.in_min;
		fin_c.outside  = car_s5.outside;
		fin_c.den_zero = (denom_c == '0);
		fin_c.pan_zero = (dlen_s5 == '0) || (rlen_s5 == '0);
		fin_c.rneg     = car_s5.rneg;
		fin_c.dneg     = car_s5.dneg;
	end

	logic                          v_dv   [QB+1];
	fin_t                          fin_dv [QB+1];
	logic [NLANE-1:0][DIV_W-1:0]   rem_dv [QB+1];
	logic [NLANE-1:0][DIV_W-1:0]   den_dv [QB+1];
	logic [NLANE-1:0][QB-1:0]      q_dv   [QB+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_dv[0] <= 1'b0;
		else if (en)
			v_dv[0] <= v_s5;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			fin_dv[0]    <= fin_c;
			q_dv[0]      <= '0;
			rem_dv[0][0] <= DIV_W'({car_s5.min_d, 35'h0});
			den_dv[0][0] <= DIV_W'(denom_c);
			for (int i = 0; i < 3; i++) begin
				rem_dv[0][1+i] <= DIV_W'({car_s5.rmag[i], 15'h0000});
				den_dv[0][1+i] <= DIV_W'(rlen_s5);
				rem_dv[0][4+i] <= DIV_W'({car_s5.dmag[i], 23'h000000});
				den_dv[0][4+i] <= DIV_W'(dlen_s5);
			end
		end
	end

	// ---------------- restoring dividers: one quotient bit per stage ----------------
	// a gain quotient with its top bit set is beyond unity and clamps later
	for (genvar k = 0; k < QB; k++) begin : g_div
		localparam int SH = QB - 1 - k;
		logic [NLANE-1:0][DIV_W-1:0] rem_n;
		logic [NLANE-1:0][QB-1:0]    q_n;
		logic [DIV_W-1:0]            trial;

		always_comb begin
			trial = '0;
			for (int l = 0; l < NLANE; l++) begin
				trial = den_dv[k][l] << SH;
				if (rem_dv[k][l] >= trial) begin
					rem_n[l] = rem_dv[k][l] - trial;
					q_n[l]   = {q_dv[k][l][QB-2:0], 1'b1};
				end else begin
					rem_n[l] = rem_dv[k][l];
					q_n[l]   = {q_dv[k][l][QB-2:0], 1'b0};
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				v_dv[k+1] <= 1'b0;
			else if (en)
				v_dv[k+1] <= v_dv[k];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				fin_dv[k+1] <= fin_dv[k];
				rem_dv[k+1] <= rem_n;
				den_dv[k+1] <= den_dv[k];
				q_dv[k+1]   <= q_n;
			end
		end
	end

	// ---------------- stage 7: gain select, signed unit components ----------------
	fin_t            fin_end;
	logic [QB-1:0]   qg;
	logic [15:0]     gain_c;
	logic [QB-1:0]   ru_c [3];
	logic [QB-1:0]   du_c [3];

	assign fin_end = fin_dv[QB];
	assign qg      = q_dv[QB][0];

	always_comb begin
		if (fin_end.in_min)
			gain_c = UNITY;
		else if (fin_end.outside || fin_end.den_zero)
			gain_c = '0;
		else if (qg > QB'(UNITY))
			gain_c = UNITY;
		else
			gain_c = qg[15:0];
		for (int i = 0; i < 3; i++) begin
			ru_c[i] = fin_end.rneg[i] ? -q_dv[QB][1+i] : q_dv[QB][1+i];
			du_c[i] = fin_end.dneg[i] ? -q_dv[QB][4+i] : q_dv[QB][4+i];
		end
	end

	logic          v_s7;
	fin_t          fin_s7;
	logic [15:0]   gain_s7;
	logic [QB-1:0] ru_s7 [3];
	logic [QB-1:0] du_s7 [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s7 <= 1'b0;
		else if (en)
			v_s7 <= v_dv[QB];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			fin_s7  <= fin_end;
			gain_s7 <= gain_c;
			ru_s7   <= ru_c;
			du_s7   <= du_c;
		end
	end

	// ---------------- stage 8: products ----------------
	logic                   pan_zero_s8;
	logic [15:0]            sid_s8;
	logic [31:0]            vprod_s8;
	logic signed [DP_W-1:0] dp_s8 [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s8 <= 1'b0;
		else if (en)
			v_s8 <= v_s7;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sid_s8      <= fin_s7.sound_id;
			pan_zero_s8 <= fin_s7.pan_zero;
			vprod_s8    <= fin_s7.volume * gain_s7;
			for (int i = 0; i < 3; i++)
				dp_s8[i] <= $signed(ru_s7[i]) * $signed(du_s7[i]);
		end
	end

	// ---------------- result assembly ----------------
	logic [17:0]             fin_w;
	logic signed [DOT_W-1:0] dot_c;
	logic [DOT_W-1:0]        dmag_c;
	logic [DOT_W-16:0]       pmag_c;
	logic [15:0]             pm16_c;

	always_comb begin
		fin_w  = vprod_s8[31:14];
		dot_c  = DOT_W'(dp_s8[0]) + DOT_W'(dp_s8[1]) + DOT_W'(dp_s8[2]);
		dmag_c = dot_c[DOT_W-1] ? -dot_c : dot_c;
		// truncation toward zero on the magnitude, then symmetric clamp
		pmag_c = dmag_c[DOT_W-1:15];
		pm16_c = (pmag_c > (DOT_W-15)'(PAN_MAX)) ? PAN_MAX : pmag_c[15:0];
		res_c.sound_id_out = sid_s8;
		res_c.final_volume = (fin_w > 18'(UNITY)) ? UNITY : fin_w[15:0];
		if (pan_zero_s8)
			res_c.pan = '0;
		else
			res_c.pan = dot_c[DOT_W-1] ? -pm16_c : pm16_c;
	end

	// ---------------- two-entry output buffer ----------------
	logic push, pop;

	assign push = v_s8 && en;
	assign pop  = head_v_q && res_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_v_q <= 1'b0;
			tail_v_q <= 1'b0;
		end else if (tail_v_q) begin
			if (pop) begin
				head_v_q <= 1'b1;
				tail_v_q <= 1'b0;
			end
		end else if (head_v_q && !pop) begin
			tail_v_q <= push;
		end else begin
			head_v_q <= push;
		end
	end

	always_ff @(posedge clk) begin
		if (tail_v_q) begin
			if (pop)
				head_q <= tail_q;
		end else if (head_v_q && !pop) begin
			if (push)
				tail_q <= res_c;
		end else if (push) begin
			head_q <= res_c;
		end
	end

	assign res_valid = head_v_q;
	assign res       = head_q;

endmodule
